// ----- design/dj_pkg.sv -----
package dj_pkg;

	// Value format: signed Q16.16
	localparam int VW = 32;
	localparam int PW = 2 * VW;

	typedef logic signed [VW-1:0] val_t;
	typedef logic signed [PW-1:0] prod_t;

	typedef struct packed {
		logic [2:0] mode;
		val_t       value_a;
		val_t       value_b;
		val_t       value_c;
		val_t       value_d;
		val_t       value_e;
		val_t       value_f;
	} dj_in_t;

	typedef struct packed {
		logic [1:0] result_kind;
		val_t       out_a;
		val_t       out_b;
		val_t       out_c;
		val_t       out_d;
		val_t       out_e;
		val_t       out_f;
	} dj_out_t;

	// Item modes
	localparam logic [2:0] MODE_THROTTLE  = 3'd0;
	localparam logic [2:0] MODE_VELOCITY  = 3'd1;
	localparam logic [2:0] MODE_POSITION  = 3'd2;
	localparam logic [2:0] MODE_FEEDBACK  = 3'd3;
	localparam logic [2:0] MODE_RAW_PITCH = 3'd4;
	localparam logic [2:0] MODE_RAW_ROLL  = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_M0_MIN = 2'd0;
	localparam logic [1:0] REG_M0_MAX = 2'd1;
	localparam logic [1:0] REG_M1_MIN = 2'd2;
	localparam logic [1:0] REG_M1_MAX = 2'd3;

	localparam val_t ONE_Q16 = val_t'(65536);
	localparam val_t INV_DIV = val_t'(80);

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MIX,
		OP_MUL,
		OP_DIV_CLAMP,
		OP_WB_CLAMP,
		OP_DIV_INV,
		OP_WB_INV,
		OP_OFS,
		OP_FB,
		OP_RAW,
		OP_CAL,
		OP_OUT
	} dj_op_t;

	typedef struct packed {
		dj_op_t     op;
		logic       load;
		logic [1:0] step;
		logic [2:0] idx;
	} dj_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       hit;
		logic       div_done;
		logic       out_busy;
	} dj_stat_t;

	// Saturate a 40-bit intermediate to the value range
	function automatic val_t sat40(input logic signed [39:0] v);
		logic signed [39:0] hi;
		logic signed [39:0] lo;
		hi = (40'sd1 <<< (VW - 1)) - 40'sd1;
		lo = -hi - 40'sd1;
		if (v > hi) begin
			return val_t'(hi);
		end
		if (v < lo) begin
			return val_t'(lo);
		end
		return val_t'(v);
	endfunction

	// Forward mix: 40*(p+r) or 40*(p-r), saturated
	function automatic val_t mix40(input val_t p, input val_t r, input logic sub);
		logic signed [39:0] s;
		logic signed [39:0] m;
		s = sub ? (40'(p) - 40'(r)) : (40'(p) + 40'(r));
		m = (s <<< 5) + (s <<< 3);
		return sat40(m);
	endfunction

endpackage

// ----- design/dj_div.sv -----
module dj_div import dj_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  prod_t num,
	input  val_t  den,
	output logic  done,
	output val_t  res
);

	localparam int CW = $clog2(PW + 1);
	localparam logic [PW-1:0] LIM = PW'(1) << (VW - 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] n_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] ad_q;
	logic          neg_q;

	logic [PW-1:0] an;
	logic [VW-1:0] ad;
	logic [VW:0]   rem_sh;
	logic [VW:0]   diff;
	logic          ge;

	// Magnitudes, rounding bias folded into the numerator
	always_comb begin
		an     = num[PW-1] ? PW'(-num) : PW'(num);
		ad     = den[VW-1] ? VW'(-den) : VW'(den);
		rem_sh = {rem_q, n_q[PW-1]};
		diff   = rem_sh - {1'b0, ad_q};
		ge     = rem_sh >= {1'b0, ad_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= an + PW'(ad >> 1);
			ad_q  <= ad;
			rem_q <= '0;
			neg_q <= num[PW-1] ^ den[VW-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
			n_q   <= {n_q[PW-2:0], ge};
		end
	end

	// Signed, saturated quotient
	always_comb begin
		if (neg_q) begin
			res = (n_q > LIM) ? val_t'(-LIM) : val_t'(-n_q);
		end else begin
			res = (n_q > LIM - PW'(1)) ? val_t'(LIM - PW'(1)) : val_t'(n_q);
		end
	end

	assign done = done_q;

endmodule

// ----- design/dj_datapath.sv -----
module dj_datapath import dj_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dj_cmd_t    cmd,
	input  dj_in_t     in_data,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  val_t       cfg_data,
	input  logic       out_stall,
	output dj_stat_t   stat,
	output logic       out_valid,
	output dj_out_t    out_data
);

	// Inverse mix constants: x/80 = (x/16)/5, rounding bias of half the divisor
	localparam prod_t       INV_BIAS = PW'(40);
	localparam logic [31:0] RECIP5   = 32'hCCCCCCCD;
	localparam int          RECIP_SH = 34;

	dj_in_t     in_q;
	val_t       cfg_q [4];
	val_t       res_q [6];
	prod_t      prod_q;
	val_t       raw_p_q, raw_r_q, raw_m0_q, raw_m1_q;
	logic [3:0] flags_q;
	val_t       off0_q, off1_q;
	logic       out_valid_q;
	dj_out_t    out_q;
	logic [31:0] inv_y_q;
	logic        inv_neg_q;

	val_t  lim, lead, other, x, y;
	logic  cond;
	prod_t mul_w;
	prod_t inv_num;
	prod_t inv_mag;
	logic [31:0] inv_y;
	logic [63:0] inv_prod;
	val_t  inv_q;
	val_t  inv_res;
	prod_t div_num;
	val_t  div_den;
	logic  div_start;
	logic  div_done;
	val_t  div_res;

	// Clamp step operands
	always_comb begin
		if (in_q.mode == MODE_VELOCITY) begin
			lim = cmd.step[0] ? ONE_Q16 : -ONE_Q16;
		end else begin
			lim = cfg_q[cmd.step];
		end
		lead  = cmd.step[1] ? res_q[1] : res_q[0];
		other = cmd.step[1] ? res_q[0] : res_q[1];
		cond  = cmd.step[0] ? (lim < lead) : (lead < lim);
		mul_w = other * lim;
	end

	// Inverse mix numerators
	always_comb begin
		case (cmd.idx[2:1])
			2'd0: begin
				x = in_q.value_a;
				y = in_q.value_b;
			end
			2'd1: begin
				x = in_q.value_c;
				y = in_q.value_d;
			end
			default: begin
				x = in_q.value_e;
				y = in_q.value_f;
			end
		endcase
		inv_num = cmd.idx[0] ? (PW'(x) - PW'(y)) : (PW'(x) + PW'(y));
		inv_mag = inv_num[PW-1] ? -inv_num : inv_num;
		inv_y   = 32'((inv_mag + INV_BIAS) >> 4);
	end

	// Divide by five through the reciprocal, then restore the sign
	always_comb begin
		inv_prod = {32'd0, inv_y_q} * {32'd0, RECIP5};
		inv_q    = val_t'(inv_prod >> RECIP_SH);
		inv_res  = inv_neg_q ? -inv_q : inv_q;
	end

	assign div_start = (cmd.op == OP_DIV_CLAMP);
	assign div_num   = prod_q;
	assign div_den   = lead;

	dj_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.res    (div_res)
	);

	// Configuration, calibration state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_M0_MIN] <= -ONE_Q16;
			cfg_q[REG_M0_MAX] <= ONE_Q16;
			cfg_q[REG_M1_MIN] <= -ONE_Q16;
			cfg_q[REG_M1_MAX] <= ONE_Q16;
			raw_p_q     <= '0;
			raw_r_q     <= '0;
			raw_m0_q    <= '0;
			raw_m1_q    <= '0;
			flags_q     <= '0;
			off0_q      <= '0;
			off1_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cfg_q[cfg_index] <= cfg_data;
			end
			case (cmd.op)
				OP_FB: begin
					raw_m0_q <= in_q.value_c;
					raw_m1_q <= in_q.value_d;
					flags_q  <= flags_q | 4'b1100;
				end
				OP_RAW: begin
					if (in_q.mode == MODE_RAW_PITCH) begin
						raw_p_q    <= in_q.value_a;
						flags_q[0] <= 1'b1;
					end else begin
						raw_r_q    <= in_q.value_a;
						flags_q[1] <= 1'b1;
					end
				end
				OP_CAL: begin
					if (&flags_q) begin
						off0_q <= sat40(40'(raw_m0_q) - 40'(mix40(raw_p_q, raw_r_q, 1'b0)));
						off1_q <= sat40(40'(raw_m1_q) - 40'(mix40(raw_p_q, raw_r_q, 1'b1)));
					end
				end
				default: begin
				end
			endcase
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working values
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		case (cmd.op)
			OP_MIX: begin
				res_q[0] <= mix40(in_q.value_a, in_q.value_b, 1'b0);
				res_q[1] <= mix40(in_q.value_a, in_q.value_b, 1'b1);
			end
			OP_MUL: prod_q <= mul_w;
			OP_WB_CLAMP: begin
				if (cmd.step[1]) begin
					res_q[1] <= lim;
					res_q[0] <= div_res;
				end else begin
					res_q[0] <= lim;
					res_q[1] <= div_res;
				end
			end
			OP_DIV_INV: begin
				inv_y_q   <= inv_y;
				inv_neg_q <= inv_num[PW-1];
			end
			OP_WB_INV: res_q[cmd.idx] <= inv_res;
			OP_OFS: begin
				res_q[0] <= sat40(40'(res_q[0]) + 40'(off0_q));
				res_q[1] <= sat40(40'(res_q[1]) + 40'(off1_q));
			end
			OP_OUT: begin
				out_q.result_kind <= in_q.mode[1:0];
				out_q.out_a <= res_q[0];
				out_q.out_b <= res_q[1];
				if (in_q.mode == MODE_FEEDBACK) begin
					out_q.out_c <= res_q[2];
					out_q.out_d <= res_q[3];
					out_q.out_e <= res_q[4];
					out_q.out_f <= res_q[5];
				end else begin
					out_q.out_c <= '0;
					out_q.out_d <= '0;
					out_q.out_e <= '0;
					out_q.out_f <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.mode     = in_q.mode;
	assign stat.hit      = cond && (lead != '0);
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && out_stall;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

// ----- design/dj_ctrl.sv -----
module dj_ctrl import dj_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dj_stat_t stat,
	output dj_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_MIX,
		S_CHK,
		S_MUL,
		S_DSTART,
		S_DWAIT,
		S_WB,
		S_OFS,
		S_FB,
		S_ISTART,
		S_IWB,
		S_RAW,
		S_CAL,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [1:0] step_q;
	logic [2:0] idx_q;

	assign in_stall = (state_q != S_IDLE);

	// Command decode
	always_comb begin
		cmd.load = in_valid && (state_q == S_IDLE);
		cmd.step = step_q;
		cmd.idx  = idx_q;
		case (state_q)
			S_MIX:    cmd.op = OP_MIX;
			S_MUL:    cmd.op = OP_MUL;
			S_DSTART: cmd.op = OP_DIV_CLAMP;
			S_WB:     cmd.op = OP_WB_CLAMP;
			S_OFS:    cmd.op = OP_OFS;
			S_FB:     cmd.op = OP_FB;
			S_ISTART: cmd.op = OP_DIV_INV;
			S_IWB:    cmd.op = OP_WB_INV;
			S_RAW:    cmd.op = OP_RAW;
			S_CAL:    cmd.op = OP_CAL;
			S_OUT:    cmd.op = stat.out_busy ? OP_NONE : OP_OUT;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					step_q <= '0;
					idx_q  <= '0;
					case (stat.mode)
						MODE_THROTTLE, MODE_VELOCITY, MODE_POSITION: state_q <= S_MIX;
						MODE_FEEDBACK: state_q <= S_FB;
						MODE_RAW_PITCH, MODE_RAW_ROLL: state_q <= S_RAW;
						default: state_q <= S_IDLE;
					endcase
				end
				S_MIX: state_q <= (stat.mode == MODE_POSITION) ? S_OFS : S_CHK;
				S_CHK: begin
					if (stat.hit) begin
						state_q <= S_MUL;
					end else if (step_q == 2'd3) begin
						state_q <= S_OUT;
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				S_MUL:    state_q <= S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (stat.div_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (step_q == 2'd3) begin
						state_q <= S_OUT;
					end else begin
						step_q  <= step_q + 2'd1;
						state_q <= S_CHK;
					end
				end
				S_OFS:    state_q <= S_OUT;
				S_FB:     state_q <= S_ISTART;
				S_ISTART: state_q <= S_IWB;
				S_IWB: begin
					if (idx_q == 3'd5) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + 3'd1;
						state_q <= S_ISTART;
					end
				end
				S_RAW: state_q <= S_CAL;
				S_CAL: state_q <= S_IDLE;
				S_OUT: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- design/differential_joint_mixer_unit.sv -----
// Differential wrist mixer: pitch/roll commands to two motor drives, and
// motor feedback back to pitch/roll, in signed Q16.16.
// Input channel: in_valid/in_stall with in_data; an item is taken when
// in_valid is high and in_stall low. Output channel: out_valid/out_stall
// with out_data, held steady while stalled. Modes 0..3 give one result,
// raw pitch/roll and unused modes give none.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects a
// throttle limit; write only while no item is in flight.
// Flow: one item at a time. Clamp divisions use a restoring divider, one
// quotient bit per cycle; each active clamp step runs multiply, divider
// start, divider wait and write-back. Position runs mix, then offset;
// throttle and velocity run mix, then check each of the four clamp steps;
// feedback divides by 80 through a reciprocal, one output at a time;
// raw pitch/roll update calibration and give no result.
// The output register lets the next item be accepted while a result waits;
// a stalled receiver holds the block only when the next result is ready.
// Reset: limits return to -1.0/+1.0, offsets to zero, raw flags clear.
module differential_joint_mixer_unit import dj_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dj_in_t     in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output dj_out_t    out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  val_t       cfg_data
);

	dj_cmd_t  cmd;
	dj_stat_t stat;

	assign cfg_ready = 1'b1;

	dj_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dj_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.stat      (stat),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ----- bench/tb_differential_joint_mixer_unit.sv -----
module tb_differential_joint_mixer_unit;
	import dj_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Modes the block ignores
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam int DRAIN_CYCLES = 500;
	localparam int HOLD_CYCLES = 3000;
	localparam int QUIET_LIMIT = 40000;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;

	// Mixer predictor and store of pending joint/motor results
	class mixer_scoreboard;
		longint lim[4];
		longint pitch_raw, roll_raw, m0_pos_raw, m1_pos_raw;
		longint m0_ofs, m1_ofs;
		logic [3:0] raw_seen;
		dj_out_t pending[$];
		int errors;

		function new();
			lim[REG_M0_MIN] = -65536;
			lim[REG_M0_MAX] = 65536;
			lim[REG_M1_MIN] = -65536;
			lim[REG_M1_MAX] = 65536;
			pitch_raw = 0; roll_raw = 0; m0_pos_raw = 0; m1_pos_raw = 0;
			m0_ofs = 0; m1_ofs = 0; raw_seen = '0; errors = 0;
		endfunction

		function void set_limit(logic [1:0] idx, val_t v);
			lim[idx] = longint'(v);
		endfunction

		function longint sat(longint v);
			if (v > VMAX) return VMAX;
			if (v < VMIN) return VMIN;
			return v;
		endfunction

		// Round to nearest, ties away from zero
		function longint div_near(longint n, longint d);
			longint an, ad, q;
			an = n < 0 ? -n : n;
			ad = d < 0 ? -d : d;
			q = (an + ad / 2) / ad;
			return ((n < 0) != (d < 0)) ? -q : q;
		endfunction

		function void scale(inout longint lead, inout longint oth, input longint l);
			if (lead == 0) return;
			oth = sat(div_near(oth * l, lead));
			lead = l;
		endfunction

		function void clamp(inout longint v1, inout longint v2,
				input longint mn1, mx1, mn2, mx2);
			if (v1 < mn1) scale(v1, v2, mn1);
			if (mx1 < v1) scale(v1, v2, mx1);
			if (v2 < mn2) scale(v2, v1, mn2);
			if (mx2 < v2) scale(v2, v1, mx2);
		endfunction

		function void recalibrate();
			if (raw_seen != 4'hF) return;
			m0_ofs = sat(m0_pos_raw - sat(40 * (pitch_raw + roll_raw)));
			m1_ofs = sat(m1_pos_raw - sat(40 * (pitch_raw - roll_raw)));
		endfunction

		function void note_input(dj_in_t it);
			longint a, b, c, d, e, f, m0, m1;
			dj_out_t r;
			a = it.value_a; b = it.value_b; c = it.value_c;
			d = it.value_d; e = it.value_e; f = it.value_f;
			r = '0;
			m0 = sat(40 * (a + b));
			m1 = sat(40 * (a - b));
			case (it.mode)
				MODE_THROTTLE: begin
					clamp(m0, m1, lim[REG_M0_MIN], lim[REG_M0_MAX],
						lim[REG_M1_MIN], lim[REG_M1_MAX]);
					r.result_kind = 2'd0;
				end
				MODE_VELOCITY: begin
					clamp(m0, m1, -65536, 65536, -65536, 65536);
					r.result_kind = 2'd1;
				end
				MODE_POSITION: begin
					m0 = sat(m0 + m0_ofs);
					m1 = sat(m1 + m1_ofs);
					r.result_kind = 2'd2;
				end
				MODE_FEEDBACK: begin
					m0 = sat(div_near(a + b, 80));
					m1 = sat(div_near(a - b, 80));
					r.out_c = val_t'(sat(div_near(c + d, 80)));
					r.out_d = val_t'(sat(div_near(c - d, 80)));
					r.out_e = val_t'(sat(div_near(e + f, 80)));
					r.out_f = val_t'(sat(div_near(e - f, 80)));
					m0_pos_raw = c; m1_pos_raw = d;
					raw_seen[3:2] = 2'b11;
					r.result_kind = 2'd3;
				end
				MODE_RAW_PITCH: begin
					pitch_raw = a; raw_seen[0] = 1'b1; recalibrate();
					return;
				end
				MODE_RAW_ROLL: begin
					roll_raw = a; raw_seen[1] = 1'b1; recalibrate();
					return;
				end
				default: return;
			endcase
			r.out_a = val_t'(m0);
			r.out_b = val_t'(m1);
			pending.push_back(r);
		endfunction

		function void check(dj_out_t got);
			dj_out_t x;
			if (pending.size() == 0) begin
				$error("unexpected result item %h", got);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (got.result_kind !== x.result_kind) begin
				$error("result_kind exp %0d got %0d", x.result_kind, got.result_kind); errors++;
			end
			if (got.out_a !== x.out_a) begin
				$error("out_a exp %0d got %0d", x.out_a, got.out_a); errors++;
			end
			if (got.out_b !== x.out_b) begin
				$error("out_b exp %0d got %0d", x.out_b, got.out_b); errors++;
			end
			if (got.out_c !== x.out_c) begin
				$error("out_c exp %0d got %0d", x.out_c, got.out_c); errors++;
			end
			if (got.out_d !== x.out_d) begin
				$error("out_d exp %0d got %0d", x.out_d, got.out_d); errors++;
			end
			if (got.out_e !== x.out_e) begin
				$error("out_e exp %0d got %0d", x.out_e, got.out_e); errors++;
			end
			if (got.out_f !== x.out_f) begin
				$error("out_f exp %0d got %0d", x.out_f, got.out_f); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	dj_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	dj_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	val_t cfg_data = '0;

	mixer_scoreboard sb = new();
	int snd_idle = 0;
	int rcv_idle = 0;
	bit hold_req = 0;
	int quiet = 0;

	differential_joint_mixer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check(out_data);
	end

	// Receiver stall, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic val_t rand_val();
		case ($urandom_range(5))
			0: case ($urandom_range(4))
				0: return val_t'(VMAX);
				1: return val_t'(VMIN);
				2: return '0;
				3: return val_t'(1);
				default: return val_t'(-1);
			endcase
			1: return val_t'(int'($urandom_range(262143)) - 131072);
			2: return val_t'(int'($urandom_range(4095)) - 2048);
			3: return val_t'(int'($urandom_range(33554431)) - 16777216);
			default: return val_t'($urandom);
		endcase
	endfunction

	function automatic dj_in_t rand_item();
		dj_in_t it;
		int k;
		it.value_a = rand_val(); it.value_b = rand_val(); it.value_c = rand_val();
		it.value_d = rand_val(); it.value_e = rand_val(); it.value_f = rand_val();
		k = $urandom_range(99);
		if (k < 25) it.mode = MODE_THROTTLE;
		else if (k < 45) it.mode = MODE_VELOCITY;
		else if (k < 65) it.mode = MODE_POSITION;
		else if (k < 80) it.mode = MODE_FEEDBACK;
		else if (k < 88) it.mode = MODE_RAW_PITCH;
		else if (k < 96) it.mode = MODE_RAW_ROLL;
		else if (k < 98) it.mode = MODE_SPARE_6;
		else it.mode = MODE_SPARE_7;
		return it;
	endfunction

	task automatic send_item(dj_in_t it);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(it);
	endtask

	// Let every result arrive and any silent item finish
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Valid stays high across a run of writes; the caller drops it
	task automatic write_limit(logic [1:0] idx, val_t v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_limit(idx, v);
	endtask

	task automatic mk_send(logic [2:0] m, val_t a, val_t b, val_t c, val_t d,
			val_t e, val_t f);
		dj_in_t it;
		it.mode = m; it.value_a = a; it.value_b = b; it.value_c = c;
		it.value_d = d; it.value_e = e; it.value_f = f;
		send_item(it);
	endtask

	initial begin
		val_t mx, mn;
		mx = val_t'(VMAX);
		mn = val_t'(VMIN);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, every mode, zero offsets, then calibration
		snd_idle = 8; rcv_idle = 87;
		mk_send(MODE_THROTTLE, mx, mx, 0, 0, 0, 0);
		mk_send(MODE_THROTTLE, mn, mx, 0, 0, 0, 0);
		mk_send(MODE_THROTTLE, 0, 0, 0, 0, 0, 0);
		mk_send(MODE_THROTTLE, val_t'(1000), val_t'(-300), 0, 0, 0, 0);
		mk_send(MODE_VELOCITY, mn, mn, 0, 0, 0, 0);
		mk_send(MODE_VELOCITY, val_t'(4096), val_t'(-1024), 0, 0, 0, 0);
		mk_send(MODE_POSITION, mx, mn, 0, 0, 0, 0);
		mk_send(MODE_POSITION, val_t'(100), val_t'(7), 0, 0, 0, 0);
		mk_send(MODE_FEEDBACK, mx, mx, mn, mn, mx, mn);
		mk_send(MODE_FEEDBACK, val_t'(40), val_t'(0), val_t'(-40), val_t'(0),
			val_t'(120), val_t'(-39));
		mk_send(MODE_SPARE_6, mx, mx, mx, mx, mx, mx);
		mk_send(MODE_SPARE_7, mn, mn, mn, mn, mn, mn);
		mk_send(MODE_POSITION, val_t'(5), val_t'(5), 0, 0, 0, 0);
		mk_send(MODE_RAW_PITCH, val_t'(30000), mx, mx, mx, mx, mx);
		mk_send(MODE_POSITION, val_t'(5), val_t'(5), 0, 0, 0, 0);
		mk_send(MODE_RAW_ROLL, val_t'(-7000), 0, 0, 0, 0, 0);
		mk_send(MODE_POSITION, val_t'(5), val_t'(-5), 0, 0, 0, 0);
		mk_send(MODE_POSITION, mx, mx, 0, 0, 0, 0);
		mk_send(MODE_POSITION, mn, 0, 0, 0, 0, 0);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: begin
					write_limit(REG_M0_MIN, mn); write_limit(REG_M0_MAX, mx);
					write_limit(REG_M1_MIN, mn); write_limit(REG_M1_MAX, mx);
				end
				1: begin
					// positive floor: zero drive cannot be scaled
					write_limit(REG_M0_MIN, ONE_Q16); write_limit(REG_M0_MAX, mx);
					write_limit(REG_M1_MIN, val_t'(-2 * 65536));
					write_limit(REG_M1_MAX, val_t'(3 * 65536));
				end
				2: begin
					write_limit(REG_M0_MIN, 0); write_limit(REG_M0_MAX, 0);
					write_limit(REG_M1_MIN, 0); write_limit(REG_M1_MAX, 0);
				end
				3: begin
					write_limit(REG_M0_MIN, mx); write_limit(REG_M0_MAX, mn);
					write_limit(REG_M1_MIN, mx); write_limit(REG_M1_MAX, mn);
				end
				default: begin
					write_limit(REG_M0_MIN, val_t'(-int'($urandom_range(1 << 20))));
					write_limit(REG_M0_MAX, val_t'($urandom_range(1 << 20)));
					write_limit(REG_M1_MIN, val_t'($urandom));
					write_limit(REG_M1_MAX, val_t'($urandom));
				end
			endcase
			cfg_valid <= 1'b0;
			if (ph < 2) begin
				snd_idle = 8; rcv_idle = 87;
			end else if (ph < 4) begin
				snd_idle = 87; rcv_idle = 8;
			end else begin
				snd_idle = 0; rcv_idle = 0;
			end
			if (ph == 4) hold_req = 1;
			mk_send(MODE_THROTTLE, 0, 0, 0, 0, 0, 0);
			for (int i = 0; i < 147; i++) send_item(rand_item());
		end

		drain();
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
